### hw/rtl/btaf_pkg.sv
// shared types, character codes and digit helpers for the bcd time ascii formatter
`timescale 1ns / 1ps
package btaf_pkg;

  localparam int MaxChars = 11;
  localparam int LenW     = $clog2(MaxChars + 1);

  typedef logic [6:0] char_t;
  typedef logic [1:0] fmt_t;
  typedef logic [7:0] bcd_t;
  typedef logic [LenW-1:0] len_t;
  typedef char_t [MaxChars-1:0] chars_t;

  typedef struct packed {
    len_t   len;
    chars_t chars;
  } str_t;

  localparam fmt_t FmtH24    = 2'd0;
  localparam fmt_t FmtH12    = 2'd1;
  localparam fmt_t FmtH24Sec = 2'd2;
  localparam fmt_t FmtH12Sec = 2'd3;

  localparam len_t LenH24    = LenW'(5);
  localparam len_t LenH12    = LenW'(8);
  localparam len_t LenH24Sec = LenW'(8);
  localparam len_t LenH12Sec = LenW'(11);

  localparam char_t CharZero  = 7'h30;
  localparam char_t CharColon = 7'h3A;
  localparam char_t CharSpace = 7'h20;
  localparam char_t CharA     = 7'h41;
  localparam char_t CharP     = 7'h50;
  localparam char_t CharM     = 7'h4D;

  // high nibble times ten plus low nibble, up to 165
  function automatic logic [7:0] bcd_decode(input bcd_t b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return 8'({hi, 3'b000} + {hi, 1'b0} + lo);
  endfunction

  // returns {(v/10)%10, v%10} for v below 200
  function automatic logic [7:0] two_digits(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  ones;
    logic [4:0]  tens;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    ones = 8'(v - 8'({3'd0, q} * 8'd10));
    tens = (q >= 5'd10) ? 5'(q - 5'd10) : q;
    return {tens[3:0], ones[3:0]};
  endfunction

  function automatic char_t digit_char(input logic [3:0] d);
    return 7'(CharZero + {3'd0, d});
  endfunction

endpackage

### hw/rtl/btaf_fmt.sv
// combinational builder of the character string for one clock reading
`timescale 1ns / 1ps
module btaf_fmt (
  input  btaf_pkg::fmt_t time_format,
  input  btaf_pkg::bcd_t hour_code,
  input  btaf_pkg::bcd_t minute_code,
  input  btaf_pkg::bcd_t second_code,
  output btaf_pkg::str_t str
);
  import btaf_pkg::*;

  logic [7:0] hours;
  logic [7:0] shown;
  logic [7:0] hdig;
  logic [7:0] mdig;
  logic [7:0] sdig;
  logic       pm;
  logic       twelve;
  char_t      ampm;

  always_comb begin
    hours  = bcd_decode(hour_code);
    twelve = time_format[0];
    shown  = hours;
    if (twelve) begin
      if (hours == 8'd0) begin
        shown = 8'd12;
      end else if (hours > 8'd12) begin
        shown = 8'(hours - 8'd12);
      end
    end
    pm   = (hours >= 8'd12);
    ampm = pm ? CharP : CharA;
    hdig = two_digits(shown);
    mdig = two_digits(bcd_decode(minute_code));
    sdig = two_digits(bcd_decode(second_code));
  end

  always_comb begin
    for (int i = 0; i < MaxChars; i++) begin
      str.chars[i] = CharSpace;
    end
    str.chars[0] = digit_char(hdig[7:4]);
    str.chars[1] = digit_char(hdig[3:0]);
    str.chars[2] = CharColon;
    str.chars[3] = digit_char(mdig[7:4]);
    str.chars[4] = digit_char(mdig[3:0]);
    case (time_format)
      FmtH24: begin
        str.len = LenH24;
      end
      FmtH12: begin
        str.len      = LenH12;
        str.chars[5] = CharSpace;
        str.chars[6] = ampm;
        str.chars[7] = CharM;
      end
      FmtH24Sec: begin
        str.len      = LenH24Sec;
        str.chars[5] = CharColon;
        str.chars[6] = digit_char(sdig[7:4]);
        str.chars[7] = digit_char(sdig[3:0]);
      end
      FmtH12Sec: begin
        str.len       = LenH12Sec;
        str.chars[5]  = CharColon;
        str.chars[6]  = digit_char(sdig[7:4]);
        str.chars[7]  = digit_char(sdig[3:0]);
        str.chars[8]  = CharSpace;
        str.chars[9]  = ampm;
        str.chars[10] = CharM;
      end
      default: begin
        str.len = LenH24;
      end
    endcase
  end

endmodule

### hw/rtl/bcd_time_ascii_formatter_unit.sv
// top level of the bcd time to ascii formatter
`timescale 1ns / 1ps
// usage:
//   input channel (in_valid / in_stall) takes one clock reading as three raw
//   bcd bytes. cfg_valid with cfg_time_format selects the format: 24h, 12h with
//   am/pm, and each with or without seconds; cfg_ready is always high. The user
//   must change the format only while no item is in flight (not enforced).
//   output channel (out_valid / out_stall) carries one ascii character per
//   item, out_last_char marks the end of the string.
// path: an accepted item sits in the input register until the output shift
//   register is free, its string is then loaded there, and the first
//   character is shown right after that load.
// throughput: one character per cycle while out_stall is low; a reading gives
//   5, 8 or 11 characters (format dependent). The next reading waits in the
//   input register and its string loads on the edge that takes the last
//   character of the previous one, with no gap.
// reset: synchronous, active low; clears both stages and the format to 24h.
// stall: out_stall holds the current character; the input register then fills
//   and in_stall rises until the string moves on.
module bcd_time_ascii_formatter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  btaf_pkg::fmt_t      cfg_time_format,
  input  logic                in_valid,
  output logic                in_stall,
  input  btaf_pkg::bcd_t      in_hour_code,
  input  btaf_pkg::bcd_t      in_minute_code,
  input  btaf_pkg::bcd_t      in_second_code,
  output logic                out_valid,
  input  logic                out_stall,
  output btaf_pkg::char_t     out_character,
  output logic                out_last_char
);
  import btaf_pkg::*;

  fmt_t   fmt_r;
  logic   s1_valid_r;
  logic   s1_valid_nxt;
  bcd_t   s1_hours_r;
  bcd_t   s1_minutes_r;
  bcd_t   s1_seconds_r;
  chars_t chars_r;
  chars_t chars_nxt;
  len_t   cnt_r;
  len_t   cnt_nxt;
  str_t   fmt_str;
  logic   in_take;
  logic   out_take;
  logic   load;

  assign cfg_ready     = 1'b1;
  assign out_valid     = (cnt_r != '0);
  assign out_character = chars_r[0];
  assign out_last_char = (cnt_r == LenW'(1));
  assign out_take      = out_valid && !out_stall;
  assign load          = s1_valid_r && (!out_valid || (out_take && out_last_char));
  assign in_stall      = s1_valid_r && !load;
  assign in_take       = in_valid && !in_stall;

  btaf_fmt u_fmt (
    .time_format (fmt_r),
    .hour_code   (s1_hours_r),
    .minute_code (s1_minutes_r),
    .second_code (s1_seconds_r),
    .str         (fmt_str)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (load) begin
      s1_valid_nxt = 1'b0;
    end
    chars_nxt = chars_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      chars_nxt = fmt_str.chars;
      cnt_nxt   = fmt_str.len;
    end else if (out_take) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        chars_nxt[i] = chars_r[i+1];
      end
      chars_nxt[MaxChars-1] = CharSpace;
      cnt_nxt = LenW'(cnt_r - LenW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FmtH24;
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fmt_r <= cfg_time_format;
      end
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_hours_r   <= in_hour_code;
      s1_minutes_r <= in_minute_code;
      s1_seconds_r <= in_second_code;
    end
    chars_r <= chars_nxt;
  end

`ifndef ASSERT_OFF
  a_load_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_valid) |-> (out_take && out_last_char))
    else $error("string reloaded before its last item was taken");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded string not shown");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (fmt_str.len == LenH24 || fmt_str.len == LenH12 ||
                    fmt_str.len == LenH12Sec))
    else $error("string length out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LenW'(MaxChars))
    else $error("character count above maximum");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(cnt_r)))
    else $error("count moved while output stalled");
`endif

endmodule

### sim/tb_bcd_time_ascii_formatter_unit.sv
// testbench for the bcd time ascii formatter: predicts each string and checks every character
`timescale 1ns / 1ps
module tb_bcd_time_ascii_formatter_unit;
  import btaf_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_char_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  fmt_t  cfg_time_format = FmtH24;
  logic  in_valid = 1'b0;
  logic  in_stall;
  bcd_t  in_hour_code = '0;
  bcd_t  in_minute_code = '0;
  bcd_t  in_second_code = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  char_t out_character;
  logic  out_last_char;

  text_char_t pending_chars[$];
  fmt_t       format_now = FmtH24;
  int         mismatches = 0;
  int         burst_left = 0;
  int         hold_off_cycles = 0;
  fmt_t       fmt_choices[4] = '{FmtH24, FmtH12, FmtH24Sec, FmtH12Sec};

  bcd_time_ascii_formatter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_time_format(cfg_time_format),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_hour_code   (in_hour_code),
    .in_minute_code (in_minute_code),
    .in_second_code (in_second_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_character  (out_character),
    .out_last_char  (out_last_char)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_bcd_time_ascii_formatter_unit: FAIL");
    $finish;
  end

  function automatic int bcd_to_int(input bcd_t b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic bcd_t int_to_bcd(input int v);
    return bcd_t'(((v / 10) << 4) | (v % 10));
  endfunction

  // expected characters of one reading under the current format
  function automatic void predict_text(input bcd_t hrs_b, input bcd_t min_b,
                                       input bcd_t sec_b);
    char_t text[$];
    int    hrs;
    int    mins;
    int    secs;
    int    shown;
    bit    twelve;
    bit    with_secs;
    hrs = bcd_to_int(hrs_b);
    mins = bcd_to_int(min_b);
    secs = bcd_to_int(sec_b);
    twelve = (format_now == FmtH12) || (format_now == FmtH12Sec);
    with_secs = (format_now == FmtH24Sec) || (format_now == FmtH12Sec);
    shown = hrs;
    if (twelve && hrs == 0) shown = 12;
    else if (twelve && hrs > 12) shown = hrs - 12;
    text.push_back(char_t'(CharZero + (shown / 10) % 10));
    text.push_back(char_t'(CharZero + shown % 10));
    text.push_back(CharColon);
    text.push_back(char_t'(CharZero + (mins / 10) % 10));
    text.push_back(char_t'(CharZero + mins % 10));
    if (with_secs) begin
      text.push_back(CharColon);
      text.push_back(char_t'(CharZero + (secs / 10) % 10));
      text.push_back(char_t'(CharZero + secs % 10));
    end
    if (twelve) begin
      text.push_back(CharSpace);
      text.push_back(hrs >= 12 ? CharP : CharA);
      text.push_back(CharM);
    end
    for (int i = 0; i < text.size(); i++) begin
      pending_chars.push_back('{text[i], i == text.size() - 1});
    end
  endfunction

  task automatic send_reading(input bcd_t hrs_b, input bcd_t min_b, input bcd_t sec_b);
    logic taken;
    in_valid <= 1'b1;
    in_hour_code <= hrs_b;
    in_minute_code <= min_b;
    in_second_code <= sec_b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_text(hrs_b, min_b, sec_b);
  endtask

  // bursts of random length with random gaps
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input fmt_t f);
    logic taken;
    drain_pending();
    cfg_valid <= 1'b1;
    cfg_time_format <= f;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    format_now = f;
  endtask

  task automatic random_reading(output bcd_t hrs_b, output bcd_t min_b, output bcd_t sec_b);
    if ($urandom_range(0, 3) != 0) begin
      hrs_b = int_to_bcd($urandom_range(0, 23));
      min_b = int_to_bcd($urandom_range(0, 59));
      sec_b = int_to_bcd($urandom_range(0, 59));
    end else begin
      hrs_b = bcd_t'($urandom);
      min_b = bcd_t'($urandom);
      sec_b = bcd_t'($urandom);
    end
  endtask

  task automatic test_reset_format();
    send_reading(8'h00, 8'h00, 8'h00);
    pace_sender();
    send_reading(8'h23, 8'h59, 8'h59);
  endtask

  // midnight, noon, afternoon and invalid nibbles under each format
  task automatic test_format_corners();
    for (int k = 3; k >= 0; k--) begin
      write_format(fmt_choices[k]);
      send_reading(8'h00, 8'h00, 8'h00);
      pace_sender();
      send_reading(8'h12, 8'h34, 8'h56);
      pace_sender();
      send_reading(8'h13, 8'h59, 8'h59);
      pace_sender();
      send_reading(8'hFF, 8'hFF, 8'hFF);
      pace_sender();
      send_reading(8'hA5, 8'h5A, 8'hF0);
    end
  endtask

  task automatic test_random_readings();
    bcd_t hrs_b;
    bcd_t min_b;
    bcd_t sec_b;
    for (int p = 0; p < 6; p++) begin
      write_format(fmt_choices[$urandom_range(0, 3)]);
      for (int n = 0; n < 36; n++) begin
        random_reading(hrs_b, min_b, sec_b);
        pace_sender();
        send_reading(hrs_b, min_b, sec_b);
      end
    end
  endtask

  // receiver holds off while items keep coming back to back
  task automatic test_output_hold_off();
    bcd_t hrs_b;
    bcd_t min_b;
    bcd_t sec_b;
    write_format(FmtH12Sec);
    hold_off_cycles = 150;
    for (int n = 0; n < 25; n++) begin
      random_reading(hrs_b, min_b, sec_b);
      send_reading(hrs_b, min_b, sec_b);
    end
  endtask

  initial begin : receiver_pace
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= (left % 5 < 2);
          default: out_stall <= ($urandom_range(0, 2) != 0);
        endcase
      end
    end
  end

  initial begin : char_checker
    text_char_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected character: got %h last %b", out_character, out_last_char);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (out_character !== want.ch) begin
            $error("character: expected %h, got %h", want.ch, out_character);
            mismatches++;
          end
          if (out_last_char !== want.last) begin
            $error("last_char: expected %b, got %b", want.last, out_last_char);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_format();
    test_format_corners();
    test_random_readings();
    test_output_hold_off();
    drain_pending();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("tb_bcd_time_ascii_formatter_unit: PASS");
    end else begin
      $display("tb_bcd_time_ascii_formatter_unit: FAIL");
    end
    $finish;
  end

endmodule
